// File: rtl/core/disk_mean_image_sampler_top_assert.svh
// Assertion macros shared by the sampler files.
`ifndef DISK_MEAN_IMAGE_SAMPLER_TOP_ASSERT_SVH
`define DISK_MEAN_IMAGE_SAMPLER_TOP_ASSERT_SVH
// An implication checked at every rising clock edge outside reset.
`define DMS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// An implication whose consequent is checked in the cycle after the antecedent.
`define DMS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/core/dms_pkg.sv
`timescale 1ns / 1ps
package dms_pkg;
    localparam int MAX_WIDTH = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_RADIUS = 15;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int RMAX2 = MAX_RADIUS * MAX_RADIUS * 256;
    localparam int QDEPTH = 2;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    typedef struct packed {
        logic        is_query;
        logic [17:0] byte_address;
        logic [7:0]  byte_value;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [15:0] radius_sq;
        logic [1:0]  channel_sel;
    } dms_item_t;
endpackage

// File: rtl/core/dms_ram.sv
`timescale 1ns / 1ps
module dms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/dms_queue.sv
`timescale 1ns / 1ps
module dms_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dms_pkg::dms_item_t push_item,
    output logic              full,
    input  logic              pop,
    output dms_pkg::dms_item_t pop_item,
    output logic              not_empty
);
    import dms_pkg::*;

    dms_item_t entry_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wptr_reg, rptr_reg;
    logic [$clog2(QDEPTH):0] count_reg;

    assign full = (count_reg == ($clog2(QDEPTH)+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop && not_empty)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + {{$clog2(QDEPTH){1'b0}}, (push && !full)}
                                   - {{$clog2(QDEPTH){1'b0}}, (pop && not_empty)};
        end
    end

`include "disk_mean_image_sampler_top_assert.svh"
    `DMS_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= ($clog2(QDEPTH)+1)'(QDEPTH))
    `DMS_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !full && !pop, not_empty)
    `DMS_ASSERT_NEXT(a_empty_stays, clk, rst_n, !not_empty && !push, !not_empty)
endmodule

// File: rtl/core/dms_engine.sv
`timescale 1ns / 1ps
module dms_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  dms_pkg::dms_item_t item,
    output logic               item_pop,
    input  logic [8:0]         width_cfg,
    input  logic [8:0]         height_cfg,
    input  logic [2:0]         chan_cfg,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [15:0]        mean_value,
    output logic               found
);
    import dms_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ADDR, S_WAIT, S_ACC, S_PIX, S_DIV, S_OUT} state_t;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int SUMW = $clog2((2*MAX_RADIUS+2)*(2*MAX_RADIUS+2)*255*256 + 1);
    localparam int CNTW = $clog2((2*MAX_RADIUS+2)*(2*MAX_RADIUS+2) + 1);

    state_t state_reg;
    logic [CW-1:0] w_reg, x0_reg, x1_reg, nx_reg;
    logic [RW-1:0] y1_reg, ny_reg;
    logic [2:0] ch_reg;
    logic [1:0] sel_reg;
    logic [15:0] px_reg, py_reg;
    logic [23:0] lim_reg;
    logic [ADDR_W:0] rowbase_reg, addr_reg;
    logic last_reg;
    logic [SUMW-1:0] sum_reg;
    logic [CNTW-1:0] count_reg;
    logic [SUMW-1:0] rem_reg;
    logic [15:0] quo_reg;
    logic [4:0] bit_reg;
    logic [15:0] mean_reg;
    logic found_reg;
    logic [7:0] rdata;

    logic ram_we;
    assign ram_we = (state_reg == S_IDLE) && item_valid && !item.is_query
                    && ({1'b0, item.byte_address} < (ADDR_W+1)'(STORE_DEPTH));

    dms_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(item.byte_address[ADDR_W-1:0]),
        .wdata(item.byte_value),
        .raddr(addr_reg[ADDR_W-1:0]),
        .rdata(rdata)
    );

    assign item_pop = (state_reg == S_IDLE) && item_valid;
    assign res_valid = (state_reg == S_OUT);
    assign mean_value = mean_reg;
    assign found = found_reg;

    logic [CW-1:0] w_c;
    logic [RW-1:0] h_c;
    logic [2:0] ch_c;
    logic [15:0] r2_c;
    logic signed [CW+1:0] xlo, xhi;
    logic signed [RW+1:0] ylo, yhi;
    logic [CW-1:0] x0_c, x1_c;
    logic [RW-1:0] y0_c, y1_c;
    logic empty_c;
    logic signed [17:0] dx, dy;
    logic signed [35:0] dx_sq, dy_sq;
    logic [33:0] dist_sq;
    logic [SUMW:0] trial;

    always_comb
    begin
        w_c = (width_cfg == 9'd0) ? CW'(1) : ((width_cfg > 9'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
              : CW'(width_cfg));
        h_c = (height_cfg == 9'd0) ? RW'(1) : ((height_cfg > 9'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT)
              : RW'(height_cfg));
        ch_c = (chan_cfg == 3'd0) ? 3'd1 : ((chan_cfg > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS)
               : chan_cfg);
        r2_c = (item.radius_sq > 16'(RMAX2)) ? 16'(RMAX2) : item.radius_sq;
        xlo = $signed({3'b0, item.point_x[15:8]}) - $signed((CW+2)'(MAX_RADIUS));
        xhi = $signed({3'b0, item.point_x[15:8]}) + $signed((CW+2)'(MAX_RADIUS + 1));
        ylo = $signed({3'b0, item.point_y[15:8]}) - $signed((RW+2)'(MAX_RADIUS));
        yhi = $signed({3'b0, item.point_y[15:8]}) + $signed((RW+2)'(MAX_RADIUS + 1));
        x0_c = (xlo < 0) ? '0 : CW'(xlo);
        y0_c = (ylo < 0) ? '0 : RW'(ylo);
        x1_c = (xhi > $signed({2'b0, w_c} - (CW+2)'(1))) ? w_c - 1'b1 : CW'(xhi);
        y1_c = (yhi > $signed({2'b0, h_c} - (RW+2)'(1))) ? h_c - 1'b1 : RW'(yhi);
        // A point far beyond the image leaves no column or no row to scan.
        empty_c = (x0_c > x1_c) || (y0_c > y1_c);
        dx = $signed({1'b0, nx_reg, 8'b0}) - $signed({2'b0, px_reg});
        dy = $signed({1'b0, ny_reg, 8'b0}) - $signed({2'b0, py_reg});
        dx_sq = dx * dx;
        dy_sq = dy * dy;
        dist_sq = 34'(dx_sq) + 34'(dy_sq);
        trial = {rem_reg, quo_reg[15]} - (SUMW+1)'(count_reg);
    end

    logic do_pix;
    always_ff @(posedge clk)
    begin
        do_pix <= (state_reg == S_ADDR) && (dist_sq <= {10'b0, lim_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            mean_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid && item.is_query)
                    begin
                        w_reg <= w_c;
                        ch_reg <= ch_c;
                        sel_reg <= item.channel_sel;
                        px_reg <= item.point_x;
                        py_reg <= item.point_y;
                        lim_reg <= {r2_c, 8'b0};
                        sum_reg <= '0;
                        count_reg <= '0;
                        x0_reg <= x0_c;
                        nx_reg <= x0_c;
                        ny_reg <= y0_c;
                        x1_reg <= x1_c;
                        y1_reg <= y1_c;
                        rowbase_reg <= '0;
                        state_reg <= (({1'b0, item.channel_sel} < ch_c) && !empty_c)
                                     ? S_WAIT : S_DIV;
                        bit_reg <= 5'd16;
                    end
                end
                S_WAIT:
                begin
                    // Row base is ny*w; built once per row, then column offset added.
                    rowbase_reg <= (ADDR_W+1)'(ny_reg) * (ADDR_W+1)'(w_reg);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    addr_reg <= (ADDR_W+1)'(((rowbase_reg + (ADDR_W+1)'(nx_reg)) * ch_reg)
                                + sel_reg);
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    // Pixel read issued; its value is checked in S_PIX on the next cycle.
                    last_reg <= (nx_reg == x1_reg) && (ny_reg == y1_reg);
                    if (nx_reg == x1_reg)
                    begin
                        nx_reg <= x0_reg;
                        ny_reg <= ny_reg + 1'b1;
                        state_reg <= S_PIX;
                    end
                    else
                    begin
                        nx_reg <= nx_reg + 1'b1;
                        state_reg <= S_PIX;
                    end
                end
                S_PIX:
                begin
                    if (do_pix && rdata != 8'd0 && rdata != 8'd255)
                    begin
                        sum_reg <= sum_reg + SUMW'(rdata);
                        count_reg <= count_reg + 1'b1;
                    end
                    if (last_reg)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (nx_reg == x0_reg)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_OUT:
                begin
                    if (!res_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (bit_reg == 5'd16)
                    begin
                        // The quotient fits in 16 bits, so the dividend's upper part
                        // starts as the remainder and only the low 16 bits shift in.
                        rem_reg <= sum_reg >> 8;
                        quo_reg <= {sum_reg[7:0], 8'b0};
                        bit_reg <= 5'd15;
                        found_reg <= (count_reg != '0);
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            mean_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else if (!trial[SUMW])
                        begin
                            rem_reg <= trial[SUMW-1:0];
                            quo_reg <= {quo_reg[14:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[SUMW-2:0], quo_reg[15]};
                            quo_reg <= {quo_reg[14:0], 1'b0};
                        end
                        if (count_reg != '0)
                        begin
                            if (bit_reg == 5'd0)
                            begin
                                state_reg <= S_OUT;
                                mean_reg <= (!trial[SUMW]) ? {quo_reg[14:0], 1'b1}
                                            : {quo_reg[14:0], 1'b0};
                            end
                            bit_reg <= bit_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "disk_mean_image_sampler_top_assert.svh"
    `DMS_ASSERT_IMPL(a_pop_idle, clk, rst_n, item_pop, state_reg == S_IDLE)
    `DMS_ASSERT_IMPL(a_mean_zero, clk, rst_n, res_valid && !found, mean_value == 16'd0)
    `DMS_ASSERT_NEXT(a_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(mean_value))
endmodule

// File: rtl/core/disk_mean_image_sampler_top.sv
`timescale 1ns / 1ps
// Disk-window mean sampler. Write transactions (cmd 0) store one image byte;
// a query transaction (cmd 1) scans the clipped window of up to
// (2*MAX_RADIUS+2) squared pixels through the single read port of the pixel
// memory, with an address, a read and an accumulate state per pixel and a
// row-base state per row, then runs a 16-step restoring divider. A short
// queue decouples input acceptance from the scanning engine. The user must write
// configuration only while the block is idle; the block itself does not enforce this.
module disk_mean_image_sampler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [17:0] byte_address,
    input  logic [7:0]  byte_value,
    input  logic [15:0] point_x,
    input  logic [15:0] point_y,
    input  logic [15:0] radius_sq,
    input  logic [1:0]  channel_sel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] mean_value,
    output logic        found,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import dms_pkg::*;

    logic [8:0] width_reg, height_reg;
    logic [2:0] chan_reg;
    dms_item_t in_item, q_item;
    logic q_full, q_ne, q_pop;

    // Configuration registers keep the written bits; clamping happens per query.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 9'd256;
            height_reg <= 9'd256;
            chan_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH: width_reg <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_CHANNELS: chan_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign in_item = '{is_query: cmd, byte_address: byte_address, byte_value: byte_value,
                       point_x: point_x, point_y: point_y, radius_sq: radius_sq,
                       channel_sel: channel_sel};
    assign in_stall = q_full;

    dms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid),
        .push_item(in_item),
        .full     (q_full),
        .pop      (q_pop),
        .pop_item (q_item),
        .not_empty(q_ne)
    );

    dms_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(q_ne),
        .item      (q_item),
        .item_pop  (q_pop),
        .width_cfg (width_reg),
        .height_cfg(height_reg),
        .chan_cfg  (chan_reg),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .mean_value(mean_value),
        .found     (found)
    );
endmodule
